/* design/bwsw_pkg.sv */
// Shared types and constants for the banked window span writer.
// Used by the register block, the segment unit and the top level.
package bwsw_pkg;

    localparam int unsigned BPP_SHIFT      = 2;
    localparam int unsigned SPAN_CAP       = 4096;
    localparam int unsigned BANK_SHIFT_MIN = 10;
    localparam int unsigned BANK_SHIFT_MAX = 16;
    localparam int unsigned GRAN_SHIFT_MAX = 6;

    localparam int unsigned ADDR_W = 28;   // byte address of a pixel
    localparam int unsigned REM_W  = 15;   // bytes left in a span
    localparam int unsigned PIX_W  = 13;   // pixels in a span

    localparam logic KIND_SELECT = 1'b0;
    localparam logic KIND_FILL   = 1'b1;

    localparam logic [1:0] REG_LINE_WIDTH = 2'd0;
    localparam logic [1:0] REG_BANK_SHIFT = 2'd1;
    localparam logic [1:0] REG_GRAN_SHIFT = 2'd2;
    localparam logic [1:0] REG_WINDOW_SEL = 2'd3;

    typedef struct packed {
        logic [12:0] line_width;
        logic [4:0]  bank_shift;   // limited to 10..16
        logic [2:0]  gran_shift;   // limited to 0..6
        logic        window_select;
    } t_cfg;

    typedef struct packed {
        logic [15:0]       bank;
        logic [21:0]       position;
        logic [15:0]       offset;
        logic [16:0]       length;
        logic [REM_W-1:0]  rem_next;
        logic [ADDR_W-1:0] addr_next;
        logic              last;
    } t_seg;

    typedef struct packed {
        logic        kind;
        logic        window_number;
        logic [21:0] bank_position;
        logic [15:0] window_offset;
        logic [16:0] fill_length;
        logic [7:0]  fill_byte;
        logic        last;
    } t_res;

endpackage

/* design/bwsw_if.sv */
// Valid/ready channel interfaces for draw commands and window commands.
// Depends on nothing but the language; payload fields follow the channel contract.
interface bwsw_cmd_if;
    logic        valid;
    logic        ready;
    logic        command;
    logic [11:0] row;
    logic [11:0] first_column;
    logic [12:0] end_column;
    logic [7:0]  fill_value;

    modport source (output valid, command, row, first_column, end_column, fill_value,
                    input ready);
    modport sink (input valid, command, row, first_column, end_column, fill_value,
                  output ready);
endinterface

interface bwsw_res_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic        window_number;
    logic [21:0] bank_position;
    logic [15:0] window_offset;
    logic [16:0] fill_length;
    logic [7:0]  fill_byte;
    logic        last;

    modport source (output valid, kind, window_number, bank_position, window_offset,
                    fill_length, fill_byte, last, input ready);
    modport sink (input valid, kind, window_number, bank_position, window_offset,
                  fill_length, fill_byte, last, output ready);
endinterface

/* design/bwsw_apb_regs.sv */
// APB register file for the window writer: line width, bank shift, granularity, window.
// Depends on bwsw_pkg; hands the limited settings to the core as a t_cfg struct.
module bwsw_apb_regs (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [3:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    output bwsw_pkg::t_cfg      o_cfg
);
    logic [12:0] r_line_width;
    logic [4:0]  r_bank_shift;
    logic [2:0]  r_gran_shift;
    logic        r_window_sel;
    logic        wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_width <= 13'd640;
            r_bank_shift <= 5'd16;
            r_gran_shift <= 3'd0;
            r_window_sel <= 1'b0;
        end else if (wr_en) begin
            case (paddr[3:2])
                bwsw_pkg::REG_LINE_WIDTH: r_line_width <= pwdata[12:0];
                bwsw_pkg::REG_BANK_SHIFT: r_bank_shift <= pwdata[4:0];
                bwsw_pkg::REG_GRAN_SHIFT: r_gran_shift <= pwdata[2:0];
                bwsw_pkg::REG_WINDOW_SEL: r_window_sel <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            bwsw_pkg::REG_LINE_WIDTH: prdata = {19'd0, r_line_width};
            bwsw_pkg::REG_BANK_SHIFT: prdata = {27'd0, r_bank_shift};
            bwsw_pkg::REG_GRAN_SHIFT: prdata = {29'd0, r_gran_shift};
            bwsw_pkg::REG_WINDOW_SEL: prdata = {31'd0, r_window_sel};
            default:                  prdata = 32'd0;
        endcase
    end

    // Clamp out-of-range settings to the supported window geometry.
    always_comb begin
        o_cfg.line_width    = r_line_width;
        o_cfg.window_select = r_window_sel;
        if (r_bank_shift < 5'(bwsw_pkg::BANK_SHIFT_MIN)) begin
            o_cfg.bank_shift = 5'(bwsw_pkg::BANK_SHIFT_MIN);
        end else if (r_bank_shift > 5'(bwsw_pkg::BANK_SHIFT_MAX)) begin
            o_cfg.bank_shift = 5'(bwsw_pkg::BANK_SHIFT_MAX);
        end else begin
            o_cfg.bank_shift = r_bank_shift;
        end
        if (r_gran_shift > 3'(bwsw_pkg::GRAN_SHIFT_MAX)) begin
            o_cfg.gran_shift = 3'(bwsw_pkg::GRAN_SHIFT_MAX);
        end else begin
            o_cfg.gran_shift = r_gran_shift;
        end
    end
endmodule

/* design/bwsw_seg_unit.sv */
// Shared segment unit: splits the current address into bank and offset, cuts the next segment.
// Depends on bwsw_pkg; reused by the sequencer for every bank select and fill segment.
module bwsw_seg_unit (
    input  logic [bwsw_pkg::ADDR_W-1:0] i_addr,
    input  logic [bwsw_pkg::REM_W-1:0]  i_rem,
    input  logic [4:0]                  i_bank_shift,
    input  logic [2:0]                  i_gran_shift,
    output bwsw_pkg::t_seg              o_seg
);
    logic [bwsw_pkg::ADDR_W-1:0] shifted;
    logic [16:0]                 bank_bytes;
    logic [16:0]                 mask;
    logic [16:0]                 avail;
    logic [16:0]                 rem_ext;

    always_comb begin
        shifted    = i_addr >> i_bank_shift;
        bank_bytes = 17'd1 << i_bank_shift;
        mask       = bank_bytes - 17'd1;
        rem_ext    = {2'd0, i_rem};

        o_seg.bank     = shifted[15:0];
        o_seg.position = 22'(shifted[15:0]) << i_gran_shift;
        o_seg.offset   = i_addr[15:0] & mask[15:0];
        avail          = bank_bytes - {1'b0, o_seg.offset};
        o_seg.length   = (rem_ext < avail) ? rem_ext : avail;
        o_seg.rem_next = i_rem - o_seg.length[bwsw_pkg::REM_W-1:0];
        o_seg.addr_next = i_addr + bwsw_pkg::ADDR_W'(o_seg.length);
        o_seg.last     = (o_seg.rem_next == '0);
    end
endmodule

/* design/banked_window_span_writer_core.sv */
// Sequence: a command is taken in idle, ST_ADDR forms the address with the row multiplier,
// then ST_SEG issues each result through the shared segment unit, holding while the output is full.
// A new command is taken only in idle, once the last fill of the previous one has been issued.
// Reset (synchronous, active low): registers 640/16/0/0, no bank mapped, output empty.
module banked_window_span_writer_core #(
    parameter int unsigned MAX_WIDTH = 4096
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    bwsw_cmd_if.sink           i_cmd,
    bwsw_res_if.source         o_res,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    localparam int unsigned MW_W = $clog2(MAX_WIDTH + 1) + 1;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_ADDR = 2'd1;
    localparam logic [1:0] ST_SEG  = 2'd2;

    bwsw_pkg::t_cfg cfg;
    bwsw_pkg::t_seg seg;

    logic [1:0]                    r_state, n_state;
    logic [11:0]                   r_row, n_row;
    logic [11:0]                   r_first, n_first;
    logic [7:0]                    r_fill, n_fill;
    logic [bwsw_pkg::REM_W-1:0]    r_rem, n_rem;
    logic [bwsw_pkg::ADDR_W-1:0]   r_addr, n_addr;
    logic [15:0]                   r_mapped_bank, n_mapped_bank;
    logic                          r_mapped_valid, n_mapped_valid;
    logic                          r_out_valid, n_out_valid;
    bwsw_pkg::t_res                r_out, n_out;

    logic                          accept;
    logic                          slot_free;
    logic                          need_sel;
    logic                          emit_sel;
    logic                          emit_fill;
    logic [MW_W-1:0]               end_clamped;
    logic [MW_W-1:0]               span;
    logic [bwsw_pkg::PIX_W-1:0]    pixels;
    logic [24:0]                   row_base;

    bwsw_apb_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // One unit serves every step of the split: bank, offset, segment length, next address.
    bwsw_seg_unit u_seg (
        .i_addr       (r_addr),
        .i_rem        (r_rem),
        .i_bank_shift (cfg.bank_shift),
        .i_gran_shift (cfg.gran_shift),
        .o_seg        (seg)
    );

    assign i_cmd.ready = (r_state == ST_IDLE);
    assign accept      = i_cmd.valid && i_cmd.ready;
    assign slot_free   = !r_out_valid || o_res.ready;
    assign need_sel    = !r_mapped_valid || (seg.bank != r_mapped_bank);
    assign emit_sel    = (r_state == ST_SEG) && slot_free && need_sel;
    assign emit_fill   = (r_state == ST_SEG) && slot_free && !need_sel;

    // Span length in pixels: one for command 0; else clamp end, empty if reversed, cap length.
    always_comb begin
        if (MW_W'(i_cmd.end_column) > MW_W'(MAX_WIDTH)) begin
            end_clamped = MW_W'(MAX_WIDTH);
        end else begin
            end_clamped = MW_W'(i_cmd.end_column);
        end
        if (end_clamped > MW_W'(i_cmd.first_column)) begin
            span = end_clamped - MW_W'(i_cmd.first_column);
        end else begin
            span = '0;
        end
        if (i_cmd.command == 1'b0) begin
            pixels = bwsw_pkg::PIX_W'(1);
        end else if (span > MW_W'(bwsw_pkg::SPAN_CAP)) begin
            pixels = bwsw_pkg::PIX_W'(bwsw_pkg::SPAN_CAP);
        end else begin
            pixels = bwsw_pkg::PIX_W'(span);
        end
    end

    assign row_base = 25'(r_row) * 25'(cfg.line_width);

    always_comb begin
        n_state        = r_state;
        n_row          = r_row;
        n_first        = r_first;
        n_fill         = r_fill;
        n_rem          = r_rem;
        n_addr         = r_addr;
        n_mapped_bank  = r_mapped_bank;
        n_mapped_valid = r_mapped_valid;
        n_out          = r_out;
        n_out_valid    = r_out_valid && !o_res.ready;

        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_row   = i_cmd.row;
                    n_first = i_cmd.first_column;
                    n_fill  = i_cmd.fill_value;
                    n_rem   = {pixels, {bwsw_pkg::BPP_SHIFT{1'b0}}};
                    n_state = ST_ADDR;
                end
            end
            ST_ADDR: begin
                // Form the start byte address from the row multiply.
                n_addr  = bwsw_pkg::ADDR_W'({(26'(row_base) + 26'(r_first)),
                                             {bwsw_pkg::BPP_SHIFT{1'b0}}});
                n_state = ST_SEG;
            end
            ST_SEG: begin
                if (emit_sel) begin
                    // Map the new bank first; stay here for the fill.
                    n_out.kind          = bwsw_pkg::KIND_SELECT;
                    n_out.window_number = cfg.window_select;
                    n_out.bank_position = seg.position;
                    n_out.window_offset = '0;
                    n_out.fill_length   = '0;
                    n_out.fill_byte     = '0;
                    n_out.last          = 1'b0;
                    n_out_valid         = 1'b1;
                    n_mapped_bank       = seg.bank;
                    n_mapped_valid      = 1'b1;
                end else if (emit_fill) begin
                    n_out.kind          = bwsw_pkg::KIND_FILL;
                    n_out.window_number = cfg.window_select;
                    n_out.bank_position = seg.position;
                    n_out.window_offset = seg.offset;
                    n_out.fill_length   = seg.length;
                    n_out.fill_byte     = r_fill;
                    n_out.last          = seg.last;
                    n_out_valid         = 1'b1;
                    n_addr              = seg.addr_next;
                    n_rem               = seg.rem_next;
                    if (seg.last) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_IDLE;
            r_mapped_bank  <= '0;
            r_mapped_valid <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            r_state        <= n_state;
            r_mapped_bank  <= n_mapped_bank;
            r_mapped_valid <= n_mapped_valid;
            r_out_valid    <= n_out_valid;
        end
    end

    // Payload registers: no reset needed.
    always_ff @(posedge i_clk) begin
        r_row   <= n_row;
        r_first <= n_first;
        r_fill  <= n_fill;
        r_rem   <= n_rem;
        r_addr  <= n_addr;
        r_out   <= n_out;
    end

    assign o_res.valid         = r_out_valid;
    assign o_res.kind          = r_out.kind;
    assign o_res.window_number = r_out.window_number;
    assign o_res.bank_position = r_out.bank_position;
    assign o_res.window_offset = r_out.window_offset;
    assign o_res.fill_length   = r_out.fill_length;
    assign o_res.fill_byte     = r_out.fill_byte;
    assign o_res.last          = r_out.last;

    // A fill marked last ends the command.
    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit_fill && seg.last |=> r_state == ST_IDLE)
        else $error("last fill did not return sequencer to idle");

    // A bank select always leaves that bank mapped.
    a_sel_maps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit_sel |=> r_mapped_valid && r_mapped_bank == $past(seg.bank))
        else $error("bank select did not update mapped bank");

    // A fill is never issued while no bank is mapped.
    a_fill_mapped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.kind == bwsw_pkg::KIND_FILL |-> r_mapped_valid)
        else $error("fill issued with no bank mapped");

    // Remaining bytes only shrink while a span is being split.
    a_rem_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_SEG && $past(r_state) == ST_SEG |-> r_rem <= $past(r_rem))
        else $error("remaining span length grew");

    // No new command is taken while a span is in progress.
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_SEG |-> !accept)
        else $error("command accepted while busy");
endmodule
